// File: hw/rtl/vep_pkg.sv
// shared types, constants and character decode functions for the voice envelope parser
package vep_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // one classified text byte on its way from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_zero;
    logic       is_colon;
    logic       b36_ok;
    logic [5:0] b36_val;
    logic       hex_ok;
    logic [3:0] hex_val;
  } vep_entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } vep_hex_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } vep_b36_t;

  function automatic vep_hex_t vep_hex_decode(logic [7:0] c);
    vep_hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic vep_b36_t vep_b36_decode(logic [7:0] c);
    vep_b36_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // "VE2:"
  function automatic logic [7:0] vep_prefix_char(logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h56;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h32;
      default: c = CHAR_COLON;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/voice_envelope_parser_core.sv
// top level of the voice envelope parser
// Parses a "VE2:" envelope text fed one byte per transfer; last_char_i marks the final
// byte, and one result transfer follows every such byte. A byte is taken every cycle while
// the queue has room: the front classifies it into a two-entry queue and the parse engine
// consumes one queue entry per cycle, the base-36 shift-and-add (x36 + digit) being combinational.
// A result sits in an output register, so bytes of the next envelope keep flowing while it
// waits; only the final byte of a following envelope waits for it, and the queue may then fill.
// A result is offered once the final byte leaves the queue and the result register loads.
module voice_envelope_parser_core #(
  parameter int unsigned KEY_BYTES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [31:0] session_id_o,
  output logic [31:0] packet_mode_o,
  output logic [7:0]  total_fragments_o,
  output logic [31:0] duration_seconds_o,
  output logic [47:0] sender_key_o,
  output logic [31:0] time_stamp_o,
  output logic        stamp_present_o
);
  import vep_pkg::*;

  vep_entry_t push_entry;
  vep_entry_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  vep_front u_front (
    .char_valid_i (in_valid_i),
    .char_ready_o (in_ready_o),
    .char_in_i    (char_in_i),
    .last_char_i  (last_char_i),
    .q_full_i     (q_full),
    .q_push_o     (push),
    .q_entry_o    (push_entry)
  );

  vep_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  vep_back #(
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .empty_i            (q_empty),
    .pop_o              (pop),
    .res_valid_o        (out_valid_o),
    .res_ready_i        (out_ready_i),
    .valid_res_o        (valid_res_o),
    .session_id_o       (session_id_o),
    .packet_mode_o      (packet_mode_o),
    .total_fragments_o  (total_fragments_o),
    .duration_seconds_o (duration_seconds_o),
    .sender_key_o       (sender_key_o),
    .time_stamp_o       (time_stamp_o),
    .stamp_present_o    (stamp_present_o)
  );

endmodule

// File: hw/rtl/vep_front.sv
// input side: takes text bytes and classifies them for the parse queue
module vep_front (
  input  logic              char_valid_i,
  output logic              char_ready_o,
  input  logic [7:0]        char_in_i,
  input  logic              last_char_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output vep_pkg::vep_entry_t q_entry_o
);
  import vep_pkg::*;

  vep_hex_t hex;
  vep_b36_t b36;

  assign hex = vep_hex_decode(char_in_i);
  assign b36 = vep_b36_decode(char_in_i);

  assign char_ready_o = !q_full_i;
  assign q_push_o     = char_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.ch       = char_in_i;
    q_entry_o.last     = last_char_i;
    q_entry_o.is_zero  = (char_in_i == 8'd0);
    q_entry_o.is_colon = (char_in_i == CHAR_COLON);
    q_entry_o.b36_ok   = b36.ok;
    q_entry_o.b36_val  = b36.val;
    q_entry_o.hex_ok   = hex.ok;
    q_entry_o.hex_val  = hex.val;
  end

endmodule

// File: hw/rtl/vep_queue.sv
// short queue of classified bytes between front and back
module vep_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vep_pkg::vep_entry_t push_entry_i,
  input  logic                pop_i,
  output vep_pkg::vep_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);
  import vep_pkg::*;

  vep_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]     count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// File: hw/rtl/vep_back.sv
// parse engine: walks the envelope fields and holds the finished result
module vep_back #(
  parameter int unsigned KEY_BYTES = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vep_pkg::vep_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                valid_res_o,
  output logic [31:0]         session_id_o,
  output logic [31:0]         packet_mode_o,
  output logic [7:0]          total_fragments_o,
  output logic [31:0]         duration_seconds_o,
  output logic [47:0]         sender_key_o,
  output logic [31:0]         time_stamp_o,
  output logic                stamp_present_o
);
  import vep_pkg::*;

  localparam int unsigned KPW      = $clog2(2 * KEY_BYTES);
  localparam logic [KPW-1:0] KPOS_LAST = KPW'(2 * KEY_BYTES - 1);

  localparam logic [3:0] PH_PREFIX0 = 4'd0;
  localparam logic [3:0] PH_SESSION = 4'd4;
  localparam logic [3:0] PH_MODE    = 4'd5;
  localparam logic [3:0] PH_TOTAL   = 4'd6;
  localparam logic [3:0] PH_KEY     = 4'd8;
  localparam logic [3:0] PH_STAMP   = 4'd9;
  localparam logic [3:0] PH_ENDED   = 4'd10;

  logic [3:0]     phase_q, phase_d;
  logic [31:0]    acc_q, acc_d;
  logic           stopped_q, stopped_d;
  logic [31:0]    session_q, session_d;
  logic [31:0]    mode_q, mode_d;
  logic [7:0]     total_q, total_d;
  logic [31:0]    dur_q, dur_d;
  logic [47:0]    key_q, key_d;
  logic [KPW-1:0] kpos_q, kpos_d;
  logic           pair_stop_q, pair_stop_d;
  logic           stamp_seen_q, stamp_seen_d;
  logic           failed_q, failed_d;

  logic           res_valid_q;
  logic           take_last;
  logic           ok;

  vep_hex_t       c0_hex;
  logic [7:0]     c0;
  logic [7:0]     pair_val;
  logic           pair_ok;
  logic [KPW-1:0] pair_idx;
  logic [31:0]    acc_step;

  assign pop_o     = !empty_i && (!head_i.last || !res_valid_q || res_ready_i);
  assign take_last = pop_o && head_i.last;

  // value of a pending key pair, first character held in the accumulator
  assign c0       = acc_q[7:0];
  assign c0_hex   = vep_hex_decode(c0);
  assign pair_idx = kpos_q >> 1;

  always_comb begin
    pair_ok  = 1'b1;
    pair_val = 8'd0;
    if (c0_hex.ok) begin
      pair_val = head_i.hex_ok ? {c0_hex.val, head_i.hex_val} : {4'd0, c0_hex.val};
    end else if ((c0 == CHAR_PLUS || c0 == CHAR_MINUS) && head_i.hex_ok) begin
      pair_val = (c0 == CHAR_MINUS) ? 8'd0 - {4'd0, head_i.hex_val}
                                    : {4'd0, head_i.hex_val};
    end else begin
      pair_ok = 1'b0;
    end
  end

  // acc * 36 + digit
  assign acc_step = (acc_q << 5) + (acc_q << 2) + {26'd0, head_i.b36_val};

  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    stopped_d    = stopped_q;
    session_d    = session_q;
    mode_d       = mode_q;
    total_d      = total_q;
    dur_d        = dur_q;
    key_d        = key_q;
    kpos_d       = kpos_q;
    pair_stop_d  = pair_stop_q;
    stamp_seen_d = stamp_seen_q;
    failed_d     = failed_q;

    if (pop_o && !failed_q && phase_q != PH_ENDED) begin
      if (head_i.is_zero) begin
        if (phase_q < PH_STAMP) begin
          failed_d = 1'b1;
        end
        phase_d = PH_ENDED;
      end else if (phase_q < PH_SESSION) begin
        if (head_i.ch != vep_prefix_char(phase_q[1:0])) begin
          failed_d = 1'b1;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end else if (phase_q < PH_KEY) begin
        if (head_i.is_colon) begin
          unique case (phase_q)
            PH_SESSION: session_d = acc_q;
            PH_MODE:    mode_d    = acc_q;
            PH_TOTAL:   total_d   = acc_q[7:0];
            default:    dur_d     = acc_q;
          endcase
          acc_d     = '0;
          stopped_d = 1'b0;
          phase_d   = phase_q + 1'b1;
        end else if (!stopped_q) begin
          if (head_i.b36_ok) begin
            acc_d = acc_step;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end else if (phase_q == PH_KEY) begin
        if (head_i.is_colon) begin
          acc_d     = '0;
          stopped_d = 1'b0;
          phase_d   = PH_STAMP;
        end else if (!pair_stop_q) begin
          if (!kpos_q[0]) begin
            acc_d = {24'd0, head_i.ch};
          end
          if (kpos_q == KPOS_LAST) begin
            pair_stop_d = 1'b1;
          end else begin
            kpos_d = kpos_q + 1'b1;
          end
        end
        // second character of a pair (a colon one included) resolves it
        if (!pair_stop_q && kpos_q[0] && pair_ok) begin
          for (int b = 0; b < 6; b++) begin
            if (int'(KEY_BYTES) - 1 - int'(pair_idx) == b) begin
              key_d[b*8 +: 8] = pair_val;
            end
          end
        end
      end else begin
        stamp_seen_d = 1'b1;
        if (!stopped_q) begin
          if (head_i.b36_ok) begin
            acc_d = acc_step;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
    end
  end

  assign ok = !failed_d && (phase_d == PH_STAMP || phase_d == PH_ENDED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREFIX0;
      acc_q        <= '0;
      stopped_q    <= 1'b0;
      session_q    <= '0;
      mode_q       <= '0;
      total_q      <= '0;
      dur_q        <= '0;
      key_q        <= '0;
      kpos_q       <= '0;
      pair_stop_q  <= 1'b0;
      stamp_seen_q <= 1'b0;
      failed_q     <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (take_last) begin
        phase_q      <= PH_PREFIX0;
        acc_q        <= '0;
        stopped_q    <= 1'b0;
        session_q    <= '0;
        mode_q       <= '0;
        total_q      <= '0;
        dur_q        <= '0;
        key_q        <= '0;
        kpos_q       <= '0;
        pair_stop_q  <= 1'b0;
        stamp_seen_q <= 1'b0;
        failed_q     <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        acc_q        <= acc_d;
        stopped_q    <= stopped_d;
        session_q    <= session_d;
        mode_q       <= mode_d;
        total_q      <= total_d;
        dur_q        <= dur_d;
        key_q        <= key_d;
        kpos_q       <= kpos_d;
        pair_stop_q  <= pair_stop_d;
        stamp_seen_q <= stamp_seen_d;
        failed_q     <= failed_d;
      end
      if (take_last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result register, zeroed fields for a rejected envelope
  always_ff @(posedge clk_i) begin
    if (take_last) begin
      valid_res_o        <= ok;
      session_id_o       <= ok ? session_d    : '0;
      packet_mode_o      <= ok ? mode_d       : '0;
      total_fragments_o  <= ok ? total_d      : '0;
      duration_seconds_o <= ok ? dur_d        : '0;
      sender_key_o       <= ok ? key_d        : '0;
      time_stamp_o       <= ok ? acc_d        : '0;
      stamp_present_o    <= ok ? stamp_seen_d : 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;

  a_reject_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !valid_res_o) |->
      (session_id_o == '0 && time_stamp_o == '0 && sender_key_o == '0 && !stamp_present_o))
    else $error("rejected envelope carries nonzero fields");

  a_fail_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !take_last) |=> failed_q)
    else $error("failure cleared before end of envelope");

  a_kpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kpos_q <= KPOS_LAST)
    else $error("key position out of range");

endmodule

// File: tb/voice_envelope_parser_core_tb.sv
// self-checking testbench for the voice envelope parser core
`timescale 1ns / 100ps

module voice_envelope_parser_core_tb;
  import vep_pkg::*;

  localparam int unsigned KEY_BYTES   = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TEXT_BYTES  = 1800;
  localparam logic [7:0]  NUL_BYTE    = 8'h00;

  // parse stages of an envelope
  localparam logic [3:0] STG_SESSION  = 4'd4;
  localparam logic [3:0] STG_MODE     = 4'd5;
  localparam logic [3:0] STG_TOTAL    = 4'd6;
  localparam logic [3:0] STG_KEY      = 4'd8;
  localparam logic [3:0] STG_STAMP    = 4'd9;
  localparam logic [3:0] STG_ENDED    = 4'd10;

  typedef struct packed {
    logic        valid;
    logic [31:0] session;
    logic [31:0] mode;
    logic [7:0]  total;
    logic [31:0] duration;
    logic [47:0] key;
    logic [31:0] stamp;
    logic        present;
  } envelope_fields_t;

  class envelope_scoreboard;
    localparam logic [31:0] PREFIX_TEXT = "VE2:";

    logic [3:0]  stage;
    logic [31:0] acc;
    bit          run_stopped;
    logic [31:0] session, mode, duration;
    logic [7:0]  total;
    logic [47:0] key;
    logic [3:0]  key_pos;
    bit          key_full;
    bit          stamp_seen;
    bit          failed;

    envelope_fields_t pending[$];
    int mismatches;
    int checked;
    int well_formed;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      stage = '0;
      acc = '0;
      run_stopped = 0;
      session = '0;
      mode = '0;
      total = '0;
      duration = '0;
      key = '0;
      key_pos = '0;
      key_full = 0;
      stamp_seen = 0;
      failed = 0;
    endfunction

    function int b36_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - "0";
      if (c >= "a" && c <= "z") return int'(c) - "a" + 10;
      if (c >= "A" && c <= "Z") return int'(c) - "A" + 10;
      return -1;
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - "0";
      if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
      if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
      return -1;
    endfunction

    function void add_digit(logic [7:0] c);
      int d;
      if (run_stopped) return;
      d = b36_of(c);
      if (d < 0) begin
        run_stopped = 1;
        return;
      end
      acc = acc * 32'd36 + 32'(d);
    endfunction

    // first character of the pair sits in the low byte of acc
    function void resolve_pair(logic [7:0] second);
      logic [7:0] first;
      logic [7:0] v;
      int hi, lo, idx;
      first = acc[7:0];
      hi = hex_of(first);
      lo = hex_of(second);
      if (hi >= 0) begin
        v = (lo >= 0) ? 8'(hi * 16 + lo) : 8'(hi);
      end else if ((first == CHAR_PLUS || first == CHAR_MINUS) && lo >= 0) begin
        v = (first == CHAR_MINUS) ? 8'(0 - lo) : 8'(lo);
      end else begin
        return;
      end
      idx = int'(key_pos >> 1) & 7;
      if (idx < KEY_BYTES && KEY_BYTES - 1 - idx < 6) key[(KEY_BYTES - 1 - idx) * 8 +: 8] = v;
    endfunction

    function void take_byte(logic [7:0] c);
      if (failed || stage >= STG_ENDED) return;
      if (c == NUL_BYTE) begin
        if (stage < STG_STAMP) failed = 1;
        stage = STG_ENDED;
        return;
      end
      if (stage < STG_SESSION) begin
        if (c != PREFIX_TEXT[31 - 8 * stage[1:0] -: 8]) failed = 1;
        else stage++;
        return;
      end
      if (stage < STG_KEY) begin
        if (c == CHAR_COLON) begin
          case (stage)
            STG_SESSION: session = acc;
            STG_MODE:    mode = acc;
            STG_TOTAL:   total = acc[7:0];
            default:     duration = acc;
          endcase
          acc = '0;
          run_stopped = 0;
          stage++;
        end else begin
          add_digit(c);
        end
        return;
      end
      if (stage == STG_KEY) begin
        if (c == CHAR_COLON) begin
          if (!key_full && key_pos[0]) resolve_pair(CHAR_COLON);
          acc = '0;
          run_stopped = 0;
          stage = STG_STAMP;
          return;
        end
        if (key_full) return;
        if (!key_pos[0]) acc = {24'd0, c};
        else resolve_pair(c);
        if (key_pos == 4'(2 * KEY_BYTES - 1)) key_full = 1;
        else key_pos++;
        return;
      end
      stamp_seen = 1;
      add_digit(c);
    endfunction

    function void note_input(logic [7:0] c, logic last);
      envelope_fields_t want;
      take_byte(c);
      if (!last) return;
      want = '0;
      if (!failed && stage >= STG_STAMP) begin
        want.valid    = 1'b1;
        want.session  = session;
        want.mode     = mode;
        want.total    = total;
        want.duration = duration;
        want.key      = key;
        want.stamp    = acc;
        want.present  = stamp_seen;
        well_formed++;
      end
      pending.push_back(want);
      clear_state();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(envelope_fields_t got);
      envelope_fields_t want;
      if (pending.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
        return;
      end
      want = pending.pop_front();
      compare_field("valid_res", 64'(got.valid), 64'(want.valid));
      compare_field("session_id", 64'(got.session), 64'(want.session));
      compare_field("packet_mode", 64'(got.mode), 64'(want.mode));
      compare_field("total_fragments", 64'(got.total), 64'(want.total));
      compare_field("duration_seconds", 64'(got.duration), 64'(want.duration));
      compare_field("sender_key", 64'(got.key), 64'(want.key));
      compare_field("time_stamp", 64'(got.stamp), 64'(want.stamp));
      compare_field("stamp_present", 64'(got.present), 64'(want.present));
      checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_in_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        valid_res_o;
  logic [31:0] session_id_o;
  logic [31:0] packet_mode_o;
  logic [7:0]  total_fragments_o;
  logic [31:0] duration_seconds_o;
  logic [47:0] sender_key_o;
  logic [31:0] time_stamp_o;
  logic        stamp_present_o;

  voice_envelope_parser_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .char_in_i          (char_in_i),
    .last_char_i        (last_char_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .valid_res_o        (valid_res_o),
    .session_id_o       (session_id_o),
    .packet_mode_o      (packet_mode_o),
    .total_fragments_o  (total_fragments_o),
    .duration_seconds_o (duration_seconds_o),
    .sender_key_o       (sender_key_o),
    .time_stamp_o       (time_stamp_o),
    .stamp_present_o    (stamp_present_o)
  );

  envelope_scoreboard sb;
  envelope_fields_t   observed;
  logic [7:0]         env_text[$];
  int                 bytes_sent;
  int                 envelopes_sent;
  int                 burst_left;
  bit                 gaps_on;
  bit                 hold_req;
  bit                 hold_active;
  int                 in_wait_cycles;
  int                 out_wait_cycles;
  int unsigned        cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sample both channels mid-cycle, where every driven value is settled
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) sb.note_input(char_in_i, last_char_i);
      if (in_valid_i && !in_ready_o) in_wait_cycles++;
      if (out_valid_o && !out_ready_i) out_wait_cycles++;
      if (out_valid_o && out_ready_i) begin
        observed.valid    = valid_res_o;
        observed.session  = session_id_o;
        observed.mode     = packet_mode_o;
        observed.total    = total_fragments_o;
        observed.duration = duration_seconds_o;
        observed.key      = sender_key_o;
        observed.stamp    = time_stamp_o;
        observed.present  = stamp_present_o;
        sb.check_result(observed);
      end
    end
  end

  // receiver: segments of steady, random, sparse and periodic readiness
  initial begin : receiver
    int seg_mode, seg_len, k;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        hold_active = 1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 0;
        hold_req = 0;
      end else begin
        seg_mode = $urandom_range(0, 3);
        seg_len = $urandom_range(10, 120);
        k = 0;
        while (k < seg_len && !hold_req) begin
          @(posedge clk_i);
          case (seg_mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= ($urandom_range(0, 7) == 0);
            default: out_ready_i <= (k % 3 != 0);
          endcase
          k++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run stopped after %0d cycles without finishing", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_b36();
    int d;
    d = $urandom_range(0, 35);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  // nonzero byte that is neither a base-36 digit nor a colon
  function automatic logic [7:0] rand_junk();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h01, 8'h2F));
      1:       return 8'($urandom_range(8'h3B, 8'h40));
      2:       return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h7B, 8'hFF));
    endcase
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) env_text.push_back(s[i]);
  endtask

  task automatic add_number_field();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
    repeat (n) env_text.push_back(rand_b36());
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) env_text.push_back(rand_junk());
      repeat ($urandom_range(0, 3)) env_text.push_back(rand_b36());
    end
    env_text.push_back(CHAR_COLON);
  endtask

  task automatic add_key_field();
    if ($urandom_range(0, 9) < 7) begin
      repeat (2 * KEY_BYTES) env_text.push_back(rand_hex());
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) env_text.push_back(rand_b36());
    end else begin
      repeat ($urandom_range(0, 16)) begin
        case ($urandom_range(0, 5))
          0, 1:    env_text.push_back(rand_hex());
          2:       env_text.push_back(CHAR_PLUS);
          3:       env_text.push_back(CHAR_MINUS);
          4:       env_text.push_back(rand_junk());
          default: env_text.push_back(rand_b36());
        endcase
      end
    end
    env_text.push_back(CHAR_COLON);
  endtask

  task automatic add_stamp_field();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return;
    repeat ($urandom_range(1, 9)) env_text.push_back(rand_b36());
    if (pick == 9) begin
      env_text.push_back($urandom_range(0, 1) ? CHAR_COLON : rand_junk());
      repeat ($urandom_range(0, 4)) env_text.push_back(rand_b36());
    end
  endtask

  task automatic build_envelope();
    int kind;
    env_text.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 96) begin
      repeat ($urandom_range(1, 8)) env_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    push_text("VE2:");
    repeat (4) add_number_field();
    add_key_field();
    add_stamp_field();
    if (kind >= 90) begin
      env_text.insert($urandom_range(0, env_text.size()), NUL_BYTE);
      repeat ($urandom_range(0, 3)) env_text.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 82) begin
      while (env_text.size() > 1 && $urandom_range(0, 3) != 0) void'(env_text.pop_back());
    end else if (kind >= 72) begin
      env_text[$urandom_range(0, 3)] = 8'($urandom_range(1, 255));
    end
  endtask

  // sender bursts: when gaps are on, a gap with in_valid_i low whenever a burst runs out
  task automatic pace();
    if (!gaps_on) return;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  task automatic drive_byte(logic [7:0] c, logic last);
    logic took;
    in_valid_i  <= 1'b1;
    char_in_i   <= c;
    last_char_i <= last;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_envelope();
    for (int i = 0; i < env_text.size(); i++) begin
      pace();
      drive_byte(env_text[i], i == env_text.size() - 1);
    end
    envelopes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit pressed;
    sb = new();
    pressed = 0;
    hold_req = 0;
    hold_active = 0;
    gaps_on = 0;
    burst_left = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    char_in_i   <= 8'h00;
    last_char_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single bad byte, a lone string end, then crafted envelopes
    env_text = '{8'hFF};
    send_envelope();
    env_text = '{NUL_BYTE};
    send_envelope();
    env_text.delete();
    push_text("VE2:zzzzzzzz:1x!9:7v:0:+f-1ag-z:A");
    env_text.push_back(NUL_BYTE);
    env_text.push_back(8'h80);
    push_text("Q");
    send_envelope();
    env_text.delete();
    push_text("VE2:1:2:3:4:0123456789aBcDef:t9:x");
    send_envelope();
    env_text.delete();
    push_text("VE2:1:2");
    env_text.push_back(NUL_BYTE);
    send_envelope();
    env_text.delete();
    push_text("VE2:::::c:");
    send_envelope();
    wait_drained();

    while (bytes_sent < TEXT_BYTES) begin
      if (!pressed && bytes_sent >= TEXT_BYTES / 3) begin
        // output held off while whole envelopes keep coming
        pressed = 1;
        hold_req = 1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (!hold_active) @(posedge clk_i);
        gaps_on = 0;
        repeat (6) begin
          build_envelope();
          send_envelope();
        end
        wait_drained();
      end
      gaps_on = ($urandom_range(0, 9) < 7);
      build_envelope();
      send_envelope();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

    $display("%0d envelopes in %0d text bytes, %0d results checked, %0d well-formed",
             envelopes_sent, bytes_sent, sb.checked, sb.well_formed);
    $display("input held back %0d cycles, output held off %0d cycles",
             in_wait_cycles, out_wait_cycles);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vep_pkg.sv
hw/rtl/vep_front.sv
hw/rtl/vep_queue.sv
hw/rtl/vep_back.sv
hw/rtl/voice_envelope_parser_core.sv
tb/voice_envelope_parser_core_tb.sv
